// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/hpi_pkg.sv =====
// Package for the hall position interpolator: codes, angle constants,
// control structs, the sector transition table and the midpoint table. No dependencies.
package hpi_pkg;

   localparam int ANGLE_W = 16;
   localparam int FRAC_W  = 16;
   localparam int STATE_W = 3;
   localparam int DIR_W   = 2;
   localparam int GAIN_W  = 16;
   localparam int POLES_W = 7;
   localparam int MODE_W  = 2;
   localparam int CHAN_W  = 2;
   localparam int SPEED_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int MAG_W   = 15;
   localparam int PROD_W  = 32;

   localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CAPTURE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESYNC  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POSITION_GAIN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTOR_POLES   = 1'd1;

   localparam logic [POLES_W-1:0] POLES_RESET = 7'd4;

   localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
   localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;
   localparam logic [DIR_W-1:0] DIR_REV  = 2'b11;

   // Angles with pi = 32768.
   localparam logic [ANGLE_W-1:0] ANG_ZERO     = 16'd0;
   localparam logic [ANGLE_W-1:0] ANG_PI       = 16'd32768;
   localparam logic [ANGLE_W-1:0] ANG_PI_BY_6  = 16'd5461;
   localparam logic [ANGLE_W-1:0] ANG_PI_BY_3  = 16'd10923;
   localparam logic [ANGLE_W-1:0] ANG_2PI_BY_3 = 16'd21845;
   localparam logic [ANGLE_W-1:0] ANG_4PI_BY_3 = 16'd43691;
   localparam logic [ANGLE_W-1:0] ANG_5PI_BY_3 = 16'd54613;

   typedef struct packed {
      logic load;      // latch the request fields
      logic mul_en;    // register a product
      logic mul_sel;   // 0: magnitude * gain, 1: integer step * pole count
      logic acc_en;    // add the remainder, split the sum
      logic step_en;   // move the angle by the scaled step
      logic event_en;  // apply a capture or resync
      logic push;      // copy the state into the result register
   } hpi_cmd_type;

   typedef struct packed {
      logic is_tick;
   } hpi_status_type;

   typedef struct packed {
      logic [STATE_W-1:0] next;  // zero marks an invalid transition
      logic [ANGLE_W-1:0] pos;
      logic [DIR_W-1:0]   dir;
   } hpi_hop_type;

   function automatic hpi_hop_type hop_lookup(input logic [STATE_W-1:0] st,
                                              input logic [CHAN_W-1:0]  ch);
      hpi_hop_type h;
      h = '{next: 3'd0, pos: ANG_ZERO, dir: DIR_NONE};
      case ({st, ch})
         5'b001_10: h = '{next: 3'd3, pos: ANG_2PI_BY_3, dir: DIR_REV};
         5'b001_11: h = '{next: 3'd5, pos: ANG_PI,       dir: DIR_FWD};
         5'b010_01: h = '{next: 3'd3, pos: ANG_PI_BY_3,  dir: DIR_FWD};
         5'b010_11: h = '{next: 3'd6, pos: ANG_ZERO,     dir: DIR_REV};
         5'b011_01: h = '{next: 3'd2, pos: ANG_PI_BY_3,  dir: DIR_REV};
         5'b011_10: h = '{next: 3'd1, pos: ANG_2PI_BY_3, dir: DIR_FWD};
         5'b100_01: h = '{next: 3'd5, pos: ANG_4PI_BY_3, dir: DIR_REV};
         5'b100_10: h = '{next: 3'd6, pos: ANG_5PI_BY_3, dir: DIR_FWD};
         5'b101_01: h = '{next: 3'd4, pos: ANG_4PI_BY_3, dir: DIR_FWD};
         5'b101_11: h = '{next: 3'd1, pos: ANG_PI,       dir: DIR_REV};
         5'b110_10: h = '{next: 3'd4, pos: ANG_5PI_BY_3, dir: DIR_REV};
         5'b110_11: h = '{next: 3'd2, pos: ANG_ZERO,     dir: DIR_FWD};
         default:   h = '{next: 3'd0, pos: ANG_ZERO,     dir: DIR_NONE};
      endcase
      return h;
   endfunction

   // Midpoint of each hall sector; the two illegal codes map to zero.
   function automatic logic [ANGLE_W-1:0] mid_guess(input logic [STATE_W-1:0] st);
      logic [ANGLE_W-1:0] a;
      a = ANG_ZERO;
      case (st)
         3'd1:    a = ANG_2PI_BY_3 + ANG_PI_BY_6;
         3'd2:    a = ANG_PI_BY_6;
         3'd3:    a = ANG_PI_BY_3 + ANG_PI_BY_6;
         3'd4:    a = ANG_4PI_BY_3 + ANG_PI_BY_6;
         3'd5:    a = ANG_PI + ANG_PI_BY_6;
         3'd6:    a = ANG_5PI_BY_3 + ANG_PI_BY_6;
         default: a = ANG_ZERO;
      endcase
      return a;
   endfunction

endpackage

// ===== sv/hpi_ctrl.sv =====
// Sequencing state machine of the hall position interpolator.
// Depends on hpi_pkg for the command and status structs.
module hpi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  hpi_pkg::hpi_status_type status,
   output hpi_pkg::hpi_cmd_type    cmd
);
   import hpi_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_ACC  = 3'd2;
   localparam logic [2:0] S_MUL2 = 3'd3;
   localparam logic [2:0] S_STEP = 3'd4;
   localparam logic [2:0] S_PUSH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       can_push;

   assign can_push  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (status.is_tick) begin
               cmd.mul_en = 1'b1;
               state_in   = S_ACC;
            end else begin
               cmd.event_en = 1'b1;
               state_in     = S_PUSH;
            end
         end
         S_ACC: begin
            cmd.acc_en = 1'b1;
            state_in   = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = 1'b1;
            state_in    = S_STEP;
         end
         S_STEP: begin
            cmd.step_en = 1'b1;
            state_in    = S_PUSH;
         end
         S_PUSH: begin
            if (can_push) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/hpi_dp.sv =====
// Datapath of the hall position interpolator: request latch, shared multiplier,
// angle state, configuration registers and result register. Depends on hpi_pkg.
module hpi_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  hpi_pkg::hpi_cmd_type              cmd,
   output hpi_pkg::hpi_status_type           status,
   input  logic [hpi_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [hpi_pkg::SPEED_W-1:0] req_speed_est,
   input  logic [hpi_pkg::CHAN_W-1:0]        req_capture_channel,
   input  logic [hpi_pkg::STATE_W-1:0]       req_hall_levels,
   input  logic                              csr_wr_en,
   input  logic [hpi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hpi_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   output logic [hpi_pkg::ANGLE_W-1:0]       rsp_angle,
   output logic signed [hpi_pkg::DIR_W-1:0]  rsp_direction,
   output logic [hpi_pkg::STATE_W-1:0]       rsp_sensor_state,
   output logic                              rsp_transition_valid
);
   import hpi_pkg::*;

   logic [MODE_W-1:0]  mode_ff;
   logic [SPEED_W-1:0] speed_ff;
   logic [CHAN_W-1:0]  chan_ff;
   logic [STATE_W-1:0] hall_ff;

   logic [GAIN_W-1:0]  gain_ff;
   logic [POLES_W-1:0] poles_ff;

   logic [ANGLE_W-1:0] angle_ff, angle_in;
   logic [FRAC_W-1:0]  frac_ff;
   logic [STATE_W-1:0] state_ff, state_in;
   logic [DIR_W-1:0]   dir_ff, dir_in;
   logic               hit_ff, hit_in;

   logic [PROD_W-1:0]  prod_ff;
   logic [FRAC_W-1:0]  whole_ff;

   logic               sign;
   logic               positive;
   logic [SPEED_W-1:0] negated;
   logic [MAG_W-1:0]   mag;
   logic [15:0]        mul_a, mul_b;
   logic [PROD_W-1:0]  sum;
   hpi_hop_type        hop;

   assign status.is_tick = (mode_ff == MODE_TICK);

   // Magnitude of the speed; the most negative value saturates.
   assign sign     = speed_ff[SPEED_W-1];
   assign positive = !sign && (speed_ff != '0);
   assign negated  = SPEED_W'(~speed_ff + 1'b1);
   always_comb begin
      if (speed_ff == {1'b1, {(SPEED_W-1){1'b0}}}) begin
         mag = {MAG_W{1'b1}};
      end else if (sign) begin
         mag = negated[MAG_W-1:0];
      end else begin
         mag = speed_ff[MAG_W-1:0];
      end
   end

   assign mul_a = cmd.mul_sel ? whole_ff : {1'b0, mag};
   assign mul_b = cmd.mul_sel ? {{(16-POLES_W){1'b0}}, poles_ff} : gain_ff;
   assign sum   = prod_ff + {{(PROD_W-FRAC_W){1'b0}}, frac_ff};
   assign hop   = hop_lookup(state_ff, chan_ff);

   always_comb begin
      angle_in = angle_ff;
      state_in = state_ff;
      dir_in   = dir_ff;
      hit_in   = hit_ff;
      if (cmd.load) begin
         hit_in = 1'b0;
      end else if (cmd.step_en) begin
         angle_in = positive ? angle_ff + prod_ff[ANGLE_W-1:0]
                             : angle_ff - prod_ff[ANGLE_W-1:0];
      end else if (cmd.event_en) begin
         case (mode_ff)
            MODE_CAPTURE: begin
               if (hop.next != '0) begin
                  angle_in = hop.pos;
                  dir_in   = hop.dir;
                  state_in = hop.next;
                  hit_in   = 1'b1;
               end else begin
                  state_in = hall_ff;
               end
            end
            MODE_RESYNC: begin
               state_in = hall_ff;
               angle_in = mid_guess(hall_ff);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= '0;
         poles_ff <= POLES_RESET;
         angle_ff <= '0;
         frac_ff  <= '0;
         state_ff <= '0;
         dir_ff   <= DIR_NONE;
         hit_ff   <= 1'b0;
      end else begin
         angle_ff <= angle_in;
         state_ff <= state_in;
         dir_ff   <= dir_in;
         hit_ff   <= hit_in;
         if (cmd.acc_en) begin
            frac_ff <= sum[FRAC_W-1:0];
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_POSITION_GAIN: gain_ff  <= csr_wr_data[GAIN_W-1:0];
               CSR_ROTOR_POLES:   poles_ff <= csr_wr_data[POLES_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         speed_ff <= req_speed_est;
         chan_ff  <= req_capture_channel;
         hall_ff  <= req_hall_levels;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.acc_en) begin
         whole_ff <= sum[PROD_W-1:FRAC_W];
      end
      if (cmd.push) begin
         rsp_angle            <= angle_ff;
         rsp_direction        <= dir_ff;
         rsp_sensor_state     <= state_ff;
         rsp_transition_valid <= hit_ff;
      end
   end

endmodule

// ===== sv/hall_position_interpolator.sv =====
// Top level of the hall position interpolator: controller and datapath.
// Depends on hpi_pkg, hpi_ctrl and hpi_dp.
//
//  Channel   Handshake          Payload
//  req       req_valid/stall    mode, speed_est, capture_channel, hall_levels
//  rsp       rsp_valid/stall    angle, direction, sensor_state, transition_valid
//  csr       csr_wr_en          csr_index, csr_wr_data (write only)
//
// A tick request reaches the result register after two passes through the one shared
// 16x16 multiplier (magnitude times gain, then whole step times pole count) with the
// remainder add between and the angle update last. Capture, resync and unused-mode
// requests pass the event step only; the next request is taken the cycle after the result
// is written at the earliest. Reset is synchronous, active high, sets a pole count of four
// and zeroes gain and angle state. A stalled result holds; one more request waits behind it.
module hall_position_interpolator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [hpi_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [hpi_pkg::SPEED_W-1:0] req_speed_est,
   input  logic [hpi_pkg::CHAN_W-1:0]         req_capture_channel,
   input  logic [hpi_pkg::STATE_W-1:0]        req_hall_levels,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [hpi_pkg::ANGLE_W-1:0]        rsp_angle,
   output logic signed [hpi_pkg::DIR_W-1:0]   rsp_direction,
   output logic [hpi_pkg::STATE_W-1:0]        rsp_sensor_state,
   output logic                               rsp_transition_valid,
   input  logic                               csr_wr_en,
   input  logic [hpi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hpi_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import hpi_pkg::*;

   // Commands flow from the controller to the datapath; the datapath reports
   // only whether the latched request is a tick.
   hpi_cmd_type    cmd;
   hpi_status_type status;

   hpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hpi_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_mode             (req_mode),
      .req_speed_est        (req_speed_est),
      .req_capture_channel  (req_capture_channel),
      .req_hall_levels      (req_hall_levels),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data),
      .rsp_angle            (rsp_angle),
      .rsp_direction        (rsp_direction),
      .rsp_sensor_state     (rsp_sensor_state),
      .rsp_transition_valid (rsp_transition_valid)
   );

endmodule

// ===== sv/hpi_checker.sv =====
// Port-level checks for the hall position interpolator, bound to the top level.
// Depends on hpi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hpi_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [hpi_pkg::MODE_W-1:0]         req_mode,
   input logic signed [hpi_pkg::SPEED_W-1:0] req_speed_est,
   input logic [hpi_pkg::CHAN_W-1:0]         req_capture_channel,
   input logic [hpi_pkg::STATE_W-1:0]        req_hall_levels,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [hpi_pkg::ANGLE_W-1:0]        rsp_angle,
   input logic signed [hpi_pkg::DIR_W-1:0]   rsp_direction,
   input logic [hpi_pkg::STATE_W-1:0]        rsp_sensor_state,
   input logic                               rsp_transition_valid,
   input logic                               csr_wr_en,
   input logic [hpi_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic [hpi_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import hpi_pkg::*;

   // A stalled result keeps its contents.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_angle) && $stable(rsp_sensor_state) && $stable(rsp_direction))

   // Only one request is in work at a time.
   `ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && !req_stall, req_stall)

   // The direction is never the unused code.
   `ASSERT_SAME(a_dir_code, clock, reset, rsp_valid, rsp_direction != 2'b10)

   // A matched transition lands in a legal sector with a known direction.
   `ASSERT_SAME(a_hit_legal, clock, reset, rsp_valid && rsp_transition_valid, rsp_direction != DIR_NONE && rsp_sensor_state != 3'd0 && rsp_sensor_state != 3'd7)

endmodule

bind hall_position_interpolator hpi_checker u_hpi_checker (.*);

// ===== tb/hall_position_interpolator_tb.sv =====
// Self-checking testbench for the hall position interpolator: random and directed requests,
// configuration phases and an in-order rotor predictor. Depends on hpi_pkg and the RTL.
module hall_position_interpolator_tb;
   import hpi_pkg::*;

   // The request mode that the block leaves unused; it must change nothing.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Idling is switched off inside this window of driver cycles.
   localparam int QUIET_FROM = 2000;
   localparam int QUIET_TO   = 3500;
   localparam int IDLE_PCT   = 29;
   localparam int PHASES     = 7;
   localparam int PHASE_REQS = 120;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic signed [SPEED_W-1:0] speed;
      logic [CHAN_W-1:0]         chan;
      logic [STATE_W-1:0]        hall;
   } hall_req_type;

   // What one result shows: the rotor after the request.
   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic [DIR_W-1:0]   dir;
      logic [STATE_W-1:0] sector;
      logic               hop_ok;
   } rotor_view_type;

   typedef struct packed {
      logic [STATE_W-1:0] next;
      logic [ANGLE_W-1:0] pos;
      logic [DIR_W-1:0]   dir;
   } sector_hop_type;

   typedef enum logic [1:0] {
      EVENT_REQUEST,
      EVENT_CSR_WRITE,
      EVENT_DRAIN
   } event_kind_type;

   typedef struct packed {
      event_kind_type         kind;
      hall_req_type           req;
      logic [CSR_IDX_W-1:0]   csr_idx;
      logic [CSR_DATA_W-1:0]  csr_data;
   } motor_event_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [MODE_W-1:0]           req_mode = MODE_TICK;
   logic signed [SPEED_W-1:0]   req_speed_est = '0;
   logic [CHAN_W-1:0]           req_capture_channel = '0;
   logic [STATE_W-1:0]          req_hall_levels = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [ANGLE_W-1:0]          rsp_angle;
   logic signed [DIR_W-1:0]     rsp_direction;
   logic [STATE_W-1:0]          rsp_sensor_state;
   logic                        rsp_transition_valid;
   logic                        csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = CSR_POSITION_GAIN;
   logic [CSR_DATA_W-1:0]       csr_wr_data = '0;

   hall_position_interpolator DUT (.*);

   // Work still to be driven: requests, register writes and pauses, in order.
   motor_event_type pending_events[$];
   // Rotor views owed by the block, oldest first.
   rotor_view_type  expected_views[$];

   // Predictor copy of the block's registers and state.
   logic [ANGLE_W-1:0] rotor_angle;
   logic [FRAC_W-1:0]  rotor_fraction;
   logic [STATE_W-1:0] rotor_sector;
   logic [DIR_W-1:0]   rotor_dir;
   logic [GAIN_W-1:0]  gain_reg;
   logic [POLES_W-1:0] poles_reg;

   // Sector as the stimulus generator expects it, to build legal capture sequences.
   logic [STATE_W-1:0] planned_sector;

   logic req_fire = 1'b0;
   int   mismatch_count = 0;
   int   cycle_count = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // Commutation table: which sector a capture on a given channel leads to. A zero next
   // sector means that the edge does not fit the current sector.
   function automatic sector_hop_type sector_hop(input logic [STATE_W-1:0] sector,
                                                 input logic [CHAN_W-1:0]  chan);
      sector_hop_type hop;
      hop = '{next: 3'd0, pos: ANG_ZERO, dir: DIR_NONE};
      case (sector)
         3'd1: begin
            if (chan == 2'd2) hop = '{3'd3, ANG_2PI_BY_3, DIR_REV};
            else if (chan == 2'd3) hop = '{3'd5, ANG_PI, DIR_FWD};
         end
         3'd2: begin
            if (chan == 2'd1) hop = '{3'd3, ANG_PI_BY_3, DIR_FWD};
            else if (chan == 2'd3) hop = '{3'd6, ANG_ZERO, DIR_REV};
         end
         3'd3: begin
            if (chan == 2'd1) hop = '{3'd2, ANG_PI_BY_3, DIR_REV};
            else if (chan == 2'd2) hop = '{3'd1, ANG_2PI_BY_3, DIR_FWD};
         end
         3'd4: begin
            if (chan == 2'd1) hop = '{3'd5, ANG_4PI_BY_3, DIR_REV};
            else if (chan == 2'd2) hop = '{3'd6, ANG_5PI_BY_3, DIR_FWD};
         end
         3'd5: begin
            if (chan == 2'd1) hop = '{3'd4, ANG_4PI_BY_3, DIR_FWD};
            else if (chan == 2'd3) hop = '{3'd1, ANG_PI, DIR_REV};
         end
         3'd6: begin
            if (chan == 2'd2) hop = '{3'd4, ANG_5PI_BY_3, DIR_REV};
            else if (chan == 2'd3) hop = '{3'd2, ANG_ZERO, DIR_FWD};
         end
         default: ;
      endcase
      return hop;
   endfunction

   // Middle of each sector, used on a resync; the two illegal codes give zero.
   function automatic logic [ANGLE_W-1:0] sector_midpoint(input logic [STATE_W-1:0] sector);
      case (sector)
         3'd1:    return ANG_2PI_BY_3 + ANG_PI_BY_6;
         3'd2:    return ANG_PI_BY_6;
         3'd3:    return ANG_PI_BY_3 + ANG_PI_BY_6;
         3'd4:    return ANG_4PI_BY_3 + ANG_PI_BY_6;
         3'd5:    return ANG_PI + ANG_PI_BY_6;
         3'd6:    return ANG_5PI_BY_3 + ANG_PI_BY_6;
         default: return ANG_ZERO;
      endcase
   endfunction

   // Applies one accepted request to the predicted rotor and returns what the block
   // should report for it.
   function automatic rotor_view_type advance_rotor(input hall_req_type r);
      logic [SPEED_W-1:0] raw;
      logic [SPEED_W-1:0] mag;
      logic [31:0]        sum;
      logic [31:0]        scaled;
      sector_hop_type     hop;
      logic               hop_ok;
      hop_ok = 1'b0;
      raw = r.speed;
      case (r.mode)
         MODE_TICK: begin
            // Magnitude of the speed, with the most negative code saturated.
            if (raw[SPEED_W-1]) mag = (raw == 16'h8000) ? 16'h7fff : ~raw + 16'd1;
            else mag = raw;
            sum = {16'd0, mag} * {16'd0, gain_reg} + {16'd0, rotor_fraction};
            rotor_fraction = sum[15:0];
            scaled = {16'd0, sum[31:16]} * {25'd0, poles_reg};
            // Only a strictly positive speed moves the angle forwards.
            if (!raw[SPEED_W-1] && raw != '0) rotor_angle = rotor_angle + scaled[15:0];
            else rotor_angle = rotor_angle - scaled[15:0];
         end
         MODE_CAPTURE: begin
            hop = sector_hop(rotor_sector, r.chan);
            if (hop.next != 3'd0) begin
               rotor_angle  = hop.pos;
               rotor_dir    = hop.dir;
               rotor_sector = hop.next;
               hop_ok       = 1'b1;
            end else begin
               rotor_sector = r.hall;
            end
         end
         MODE_RESYNC: begin
            rotor_sector = r.hall;
            rotor_angle  = sector_midpoint(r.hall);
         end
         default: ;
      endcase
      return '{angle: rotor_angle, dir: rotor_dir, sector: rotor_sector, hop_ok: hop_ok};
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
   endtask

   // Queues one request and follows its effect on the sector, so that later captures
   // can be chosen to fit.
   task automatic add_request(input hall_req_type r);
      sector_hop_type hop;
      hop = sector_hop(planned_sector, r.chan);
      if (r.mode == MODE_CAPTURE) planned_sector = (hop.next != 3'd0) ? hop.next : r.hall;
      else if (r.mode == MODE_RESYNC) planned_sector = r.hall;
      pending_events.push_back('{EVENT_REQUEST, r, CSR_POSITION_GAIN, 16'd0});
   endtask

   task automatic add_csr_write(input logic [CSR_IDX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] data);
      pending_events.push_back('{EVENT_CSR_WRITE, hall_req_type'(0), idx, data});
   endtask

   function automatic hall_req_type make_req(input logic [MODE_W-1:0] mode,
                                             input logic [SPEED_W-1:0] speed,
                                             input logic [CHAN_W-1:0] chan,
                                             input logic [STATE_W-1:0] hall);
      return '{mode: mode, speed: speed, chan: chan, hall: hall};
   endfunction

   // A random request. Most captures follow the commutation sequence from the sector the
   // rotor is in, so that the table is walked in both directions; the fields a mode does
   // not use are always random.
   task automatic add_random_request();
      hall_req_type   r;
      sector_hop_type hop;
      int             pick;
      int             corner;
      pick = $urandom_range(99);
      r.speed = SPEED_W'($urandom);
      r.chan  = CHAN_W'($urandom);
      r.hall  = ($urandom_range(7) == 0) ? STATE_W'($urandom_range(7))
                                         : STATE_W'($urandom_range(1, 6));
      if (pick < 45) begin
         r.mode = MODE_TICK;
         corner = $urandom_range(9);
         if (corner == 0) begin
            case ($urandom_range(5))
               0: r.speed = 16'h7fff;
               1: r.speed = 16'h8000;
               2: r.speed = 16'h8001;
               3: r.speed = 16'hffff;
               4: r.speed = 16'h0001;
               default: r.speed = 16'h0000;
            endcase
         end else if (corner < 4) begin
            r.speed = SPEED_W'($urandom_range(2000));
            if ($urandom_range(1)) r.speed = -r.speed;
         end
      end else if (pick < 83) begin
         r.mode = MODE_CAPTURE;
         if (planned_sector != 3'd0 && planned_sector != 3'd7 && $urandom_range(3) != 0) begin
            do begin
               r.chan = CHAN_W'($urandom_range(1, 3));
               hop = sector_hop(planned_sector, r.chan);
            end while (hop.next == 3'd0);
         end
      end else if (pick < 95) begin
         r.mode = MODE_RESYNC;
      end else begin
         r.mode = MODE_UNUSED;
      end
      add_request(r);
   endtask

   // Scoreboard. Register writes and accepted requests update the predictor at the same
   // edge as the block; each accepted result is compared with the oldest expectation.
   always @(posedge clock) begin
      rotor_view_type want;
      req_fire = !reset && req_valid && !req_stall;
      if (reset) begin
         rotor_angle    = '0;
         rotor_fraction = '0;
         rotor_sector   = '0;
         rotor_dir      = DIR_NONE;
         gain_reg       = '0;
         poles_reg      = POLES_RESET;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_POSITION_GAIN: gain_reg  = csr_wr_data;
               CSR_ROTOR_POLES:   poles_reg = csr_wr_data[POLES_W-1:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            expected_views.push_back(advance_rotor(make_req(req_mode, req_speed_est,
                                                            req_capture_channel,
                                                            req_hall_levels)));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_views.size() == 0) begin
               report_mismatch("result with nothing expected, angle", rsp_angle, 16'd0);
            end else begin
               want = expected_views.pop_front();
               if (rsp_angle !== want.angle)
                  report_mismatch("angle", rsp_angle, want.angle);
               if (rsp_direction !== want.dir)
                  report_mismatch("direction", 16'(rsp_direction), 16'(signed'(want.dir)));
               if (rsp_sensor_state !== want.sector)
                  report_mismatch("sensor_state", 16'(rsp_sensor_state), 16'(want.sector));
               if (rsp_transition_valid !== want.hop_ok)
                  report_mismatch("transition_valid", 16'(rsp_transition_valid),
                                  16'(want.hop_ok));
            end
         end
      end
   end

   // Driver and result-side stall. Everything changes at the falling edge. A request that
   // has not been taken holds its payload; a register write or a pause waits until every
   // owed result has been collected, which leaves the block idle.
   always @(negedge clock) begin
      motor_event_type ev;
      logic            quiet;
      logic            next_valid;
      logic            next_wr;
      cycle_count++;
      quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);
      next_valid = req_valid;
      next_wr = 1'b0;
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      if (!reset && (!req_valid || req_fire)) begin
         next_valid = 1'b0;
         if (pending_events.size() != 0) begin
            ev = pending_events[0];
            if (ev.kind == EVENT_REQUEST) begin
               if (quiet || $urandom_range(99) >= IDLE_PCT) begin
                  req_mode            <= ev.req.mode;
                  req_speed_est       <= ev.req.speed;
                  req_capture_channel <= ev.req.chan;
                  req_hall_levels     <= ev.req.hall;
                  next_valid = 1'b1;
                  void'(pending_events.pop_front());
               end
            end else if (expected_views.size() == 0) begin
               if (ev.kind == EVENT_CSR_WRITE) begin
                  csr_index   <= ev.csr_idx;
                  csr_wr_data <= ev.csr_data;
                  next_wr = 1'b1;
               end
               void'(pending_events.pop_front());
            end
         end
      end
      req_valid <= next_valid;
      csr_wr_en <= next_wr;
   end

   // Stimulus and end of run.
   initial begin
      logic [GAIN_W-1:0]  gain;
      logic [POLES_W-1:0] poles;
      planned_sector = 3'd0;

      // Directed part. With the reset gain of zero a tick must not move the angle, the
      // unused mode must change nothing, and a capture from sector zero is never valid.
      add_request(make_req(MODE_TICK,    16'h7fff, 2'd0, 3'd0));
      add_request(make_req(MODE_UNUSED,  16'h8000, 2'd3, 3'd7));
      add_request(make_req(MODE_CAPTURE, 16'h0000, 2'd0, 3'd5));
      add_request(make_req(MODE_CAPTURE, 16'h1234, 2'd1, 3'd2));
      // Largest gain and a pole count of 64; the pole data carries junk in its upper bits.
      add_csr_write(CSR_POSITION_GAIN, 16'hffff);
      add_csr_write(CSR_ROTOR_POLES,   16'hffc0);
      // Speed extremes, including the most negative code that saturates, and zero.
      add_request(make_req(MODE_TICK, 16'h7fff, 2'd3, 3'd7));
      add_request(make_req(MODE_TICK, 16'h8000, 2'd0, 3'd0));
      add_request(make_req(MODE_TICK, 16'h8001, 2'd1, 3'd1));
      add_request(make_req(MODE_TICK, 16'hffff, 2'd2, 3'd2));
      add_request(make_req(MODE_TICK, 16'h0001, 2'd3, 3'd4));
      add_request(make_req(MODE_TICK, 16'h0000, 2'd0, 3'd6));
      // Resync into the two illegal sectors and then a legal one.
      add_request(make_req(MODE_RESYNC, 16'hffff, 2'd3, 3'd7));
      add_request(make_req(MODE_RESYNC, 16'h0000, 2'd0, 3'd0));
      add_request(make_req(MODE_RESYNC, 16'h5555, 2'd2, 3'd1));
      // A walk through the table in both directions, then a capture that does not fit.
      add_request(make_req(MODE_CAPTURE, 16'haaaa, 2'd3, 3'd0));
      add_request(make_req(MODE_CAPTURE, 16'h0f0f, 2'd3, 3'd7));
      add_request(make_req(MODE_CAPTURE, 16'hf0f0, 2'd2, 3'd0));
      add_request(make_req(MODE_CAPTURE, 16'h0000, 2'd1, 3'd0));
      add_request(make_req(MODE_CAPTURE, 16'h0000, 2'd3, 3'd0));
      add_request(make_req(MODE_CAPTURE, 16'h0000, 2'd2, 3'd0));
      add_request(make_req(MODE_CAPTURE, 16'h0000, 2'd2, 3'd0));
      add_request(make_req(MODE_CAPTURE, 16'h0000, 2'd3, 3'd0));
      add_request(make_req(MODE_CAPTURE, 16'h0000, 2'd2, 3'd3));
      add_request(make_req(MODE_UNUSED,  16'h7fff, 2'd1, 3'd5));
      add_request(make_req(MODE_RESYNC,  16'h8000, 2'd1, 3'd6));

      // Random phases, each under its own gain and pole count. Pole counts of zero and
      // 127 lie outside the nominal range and are used as written.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin gain = 16'd1;             poles = 7'd1;                  end
            1: begin
               gain  = GAIN_W'($urandom);
               poles = POLES_W'($urandom_range(1, 64));
            end
            2: begin gain = 16'd0;             poles = 7'd127;                end
            3: begin gain = GAIN_W'($urandom); poles = 7'd0;                  end
            4: begin
               gain  = GAIN_W'($urandom_range(255));
               poles = POLES_W'($urandom_range(1, 64));
            end
            5: begin gain = 16'h8000;          poles = POLES_RESET;           end
            default: begin gain = 16'hffff;    poles = 7'd64;                 end
         endcase
         add_csr_write(CSR_POSITION_GAIN, gain);
         add_csr_write(CSR_ROTOR_POLES, {9'($urandom), poles});
         for (int n = 0; n < PHASE_REQS; n++) begin
            // Now and then the sender holds off until every owed result is back.
            if ($urandom_range(49) == 0)
               pending_events.push_back('{EVENT_DRAIN, hall_req_type'(0), CSR_POSITION_GAIN,
                                          16'd0});
            add_random_request();
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_events.size() != 0 || req_valid || expected_views.size() != 0)
         @(negedge clock);
      // Time for any stray result to show up.
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #(8 * 400000);
      $display("TB_ERROR");
      $finish;
   end

endmodule
